/* rtl/lru_lfu_key_cache_directory_core_macros.svh */
// Assertion macros shared by the checker
`ifndef LRU_LFU_KEY_CACHE_DIRECTORY_CORE_MACROS_SVH
`define LRU_LFU_KEY_CACHE_DIRECTORY_CORE_MACROS_SVH
// a implies b at the same edge
`define LKC_ASSERT_IMP(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("lkc check failed");
// a implies b at the next edge
`define LKC_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("lkc check failed");
`endif

/* rtl/lkc_pkg.sv */
`default_nettype none
package lkc_pkg;
    localparam logic [1:0] FUNC_GET = 2'd0;
    localparam logic [1:0] FUNC_PUT = 2'd1;
    localparam logic [1:0] FUNC_DEL = 2'd2;
    localparam logic       CFG_POLICY = 1'b0;
    localparam logic       CFG_CAP    = 1'b1;
    localparam int unsigned COUNT_MAX = 9998;
    localparam int unsigned COUNT_BITS = 14;
endpackage
`default_nettype wire

/* rtl/lkc_if.sv */
`default_nettype none
interface lkc_req_if #(parameter int KB = 32, parameter int VB = 32);
    logic          valid;
    logic          ready;
    logic [1:0]    func;
    logic [KB-1:0] req_key;
    logic [VB-1:0] req_value;
    logic          in_store;
    modport source (output valid, func, req_key, req_value, in_store, input ready);
    modport sink   (input valid, func, req_key, req_value, in_store, output ready);
endinterface

interface lkc_rsp_if #(parameter int KB = 32, parameter int VB = 32);
    logic          valid;
    logic          ready;
    logic          status;
    logic          hit;
    logic [VB-1:0] value_out;
    logic          evict_valid;
    logic [KB-1:0] evict_key;
    logic          store_write;
    logic          store_delete;
    modport source (output valid, status, hit, value_out, evict_valid, evict_key,
                    store_write, store_delete, input ready);
    modport sink   (input valid, status, hit, value_out, evict_valid, evict_key,
                    store_write, store_delete, output ready);
endinterface

interface lkc_cfg_if;
    logic       valid;
    logic       ready;
    logic [0:0] index;
    logic [4:0] data;
    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/lkc_front.sv */
`default_nettype none
// Front: takes request beats into a two-entry queue
module lkc_front #(
    parameter int KB = 32,
    parameter int VB = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    lkc_req_if.sink            req,
    input  wire logic          i_pop,
    output logic               o_valid,
    output logic [1:0]         o_func,
    output logic [KB-1:0]      o_key,
    output logic [VB-1:0]      o_value,
    output logic               o_store
);
    localparam int W = 2 + KB + VB + 1;
    logic [W-1:0] r_q [2];
    logic         r_rd, r_wr;
    logic [1:0]   r_cnt;
    logic         push;

    assign req.ready = (r_cnt != 2'd2);
    assign push = req.valid && req.ready;
    assign o_valid = (r_cnt != 2'd0);
    assign {o_func, o_key, o_value, o_store} = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wr] <= {req.func, req.req_key, req.req_value, req.in_store};
        if (!i_rst_n) begin
            r_rd <= 1'b0; r_wr <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wr <= ~r_wr;
            if (i_pop) r_rd <= ~r_rd;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, i_pop};
        end
    end
endmodule
`default_nettype wire

/* rtl/lkc_back.sv */
`default_nettype none
// Back: scans the entries for a match, then for a victim, then updates
module lkc_back #(
    parameter int CAPACITY = 16,
    parameter int KB = 32,
    parameter int VB = 32
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_pop,
    input  wire logic [1:0]    i_func,
    input  wire logic [KB-1:0] i_key,
    input  wire logic [VB-1:0] i_value,
    input  wire logic          i_store,
    input  wire logic          i_policy,
    input  wire logic [4:0]    i_cap,
    lkc_rsp_if.source          rsp
);
    import lkc_pkg::*;
    localparam int IB = $clog2(CAPACITY);
    localparam int AB = $clog2(CAPACITY);
    localparam int OB = $clog2(CAPACITY + 1);
    localparam int CB = COUNT_BITS;

    typedef enum logic [2:0] {S_IDLE, S_FIND, S_VICT, S_UPD, S_OUT} t_state;

    logic [KB-1:0] r_ekey [CAPACITY];
    logic [VB-1:0] r_eval [CAPACITY];
    logic          r_evld [CAPACITY];
    logic [AB-1:0] r_eage [CAPACITY];
    logic [CB-1:0] r_ecnt [CAPACITY];
    logic [OB-1:0] r_occ;

    t_state        r_st;
    logic [IB-1:0] r_i;
    logic          r_found;
    logic [IB-1:0] r_e;
    logic          r_bvld;
    logic [IB-1:0] r_b;
    logic          r_hasfree;
    logic [IB-1:0] r_free;
    logic          r_status, r_hit, r_evv, r_sw, r_sd;
    logic [VB-1:0] r_vout;
    logic [KB-1:0] r_evk;

    // effective capacity clamp
    logic [OB-1:0] cap_eff;
    always_comb begin
        if (i_cap == 5'd0) cap_eff = OB'(1);
        else if (32'(i_cap) > CAPACITY) cap_eff = OB'(CAPACITY);
        else cap_eff = OB'(i_cap);
    end

    logic last;
    assign last = (32'(r_i) == CAPACITY - 1);
    logic better;
    always_comb begin
        if (!r_bvld) better = 1'b1;
        else if (i_policy)
            better = (r_ecnt[r_i] < r_ecnt[r_b]) ||
                     (r_ecnt[r_i] == r_ecnt[r_b] && r_eage[r_i] > r_eage[r_b]);
        else better = r_eage[r_i] > r_eage[r_b];
    end

    assign o_pop = (r_st == S_OUT) && rsp.ready;
    assign rsp.valid = (r_st == S_OUT);
    assign rsp.status = r_status;
    assign rsp.hit = r_hit;
    assign rsp.value_out = r_vout;
    assign rsp.evict_valid = r_evv;
    assign rsp.evict_key = r_evk;
    assign rsp.store_write = r_sw;
    assign rsp.store_delete = r_sd;

    // update step, all entries in parallel
    logic          do_ins, do_evict;
    logic [IB-1:0] slot;
    logic          slot_ok;
    logic [CB-1:0] ins_cnt;
    always_comb begin
        do_ins = 1'b0;
        do_evict = 1'b0;
        if (!r_found && (i_func == FUNC_PUT || (i_func == FUNC_GET && i_store)))
            do_ins = 1'b1;
        if (do_ins && r_occ >= cap_eff && r_bvld) do_evict = 1'b1;
        slot = do_evict ? r_b : r_free;
        slot_ok = do_evict || r_hasfree;
        ins_cnt = (i_func == FUNC_GET) ? CB'(1) : CB'(0);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE;
            r_occ <= '0;
            for (int k = 0; k < CAPACITY; k++) begin
                r_evld[k] <= 1'b0; r_eage[k] <= '0; r_ecnt[k] <= '0;
            end
        end else begin
            case (r_st)
                S_IDLE: if (i_valid) begin
                    r_st <= S_FIND; r_i <= '0; r_found <= 1'b0;
                    r_bvld <= 1'b0; r_hasfree <= 1'b0;
                end
                // key match and first free slot
                S_FIND: begin
                    if (r_evld[r_i] && r_ekey[r_i] == i_key && !r_found) begin
                        r_found <= 1'b1; r_e <= r_i;
                    end
                    if (!r_evld[r_i] && !r_hasfree) begin
                        r_hasfree <= 1'b1; r_free <= r_i;
                    end
                    r_i <= last ? '0 : r_i + 1'b1;
                    if (last) r_st <= S_VICT;
                end
                // victim scan
                S_VICT: begin
                    if (r_evld[r_i] && better) begin
                        r_bvld <= 1'b1; r_b <= r_i;
                    end
                    r_i <= last ? '0 : r_i + 1'b1;
                    if (last) r_st <= S_UPD;
                end
                S_UPD: begin
                    r_status <= 1'b0; r_hit <= 1'b0; r_vout <= '0; r_evv <= 1'b0;
                    r_evk <= '0; r_sw <= 1'b0; r_sd <= 1'b0;
                    r_st <= S_OUT;
                    if (r_found && (i_func == FUNC_GET || i_func == FUNC_PUT)) begin
                        // hit: touch and count
                        for (int k = 0; k < CAPACITY; k++)
                            if (r_evld[k] && r_eage[k] < r_eage[r_e])
                                r_eage[k] <= r_eage[k] + 1'b1;
                        r_eage[r_e] <= '0;
                        if (32'(r_ecnt[r_e]) < COUNT_MAX) r_ecnt[r_e] <= r_ecnt[r_e] + 1'b1;
                        r_hit <= 1'b1;
                        if (i_func == FUNC_GET) r_vout <= r_eval[r_e];
                        else begin r_eval[r_e] <= i_value; r_sw <= 1'b1; end
                    end else if (do_ins) begin
                        if (i_func == FUNC_GET) r_vout <= i_value;
                        else r_sw <= 1'b1;
                        if (do_evict) begin
                            r_evv <= 1'b1;
                            r_evk <= r_ekey[r_b];
                        end
                        if (slot_ok) begin
                            // drop victim, then age the others; entries older than the victim keep their age
                            for (int k = 0; k < CAPACITY; k++) begin
                                if (r_evld[k] && !(do_evict && IB'(k) == r_b)) begin
                                    if (do_evict && r_eage[k] > r_eage[r_b]) begin
                                        if (r_eage[k] - 1'b1 < AB'(CAPACITY - 1))
                                            r_eage[k] <= r_eage[k];
                                        else r_eage[k] <= r_eage[k] - 1'b1;
                                    end else if (32'(r_eage[k]) < CAPACITY - 1)
                                        r_eage[k] <= r_eage[k] + 1'b1;
                                end
                            end
                            r_ekey[slot] <= i_key; r_eval[slot] <= i_value;
                            r_evld[slot] <= 1'b1; r_eage[slot] <= '0;
                            r_ecnt[slot] <= ins_cnt;
                            if (!do_evict) r_occ <= r_occ + 1'b1;
                        end else if (do_evict) begin
                            for (int k = 0; k < CAPACITY; k++)
                                if (r_evld[k] && r_eage[k] > r_eage[r_b])
                                    r_eage[k] <= r_eage[k] - 1'b1;
                            r_evld[r_b] <= 1'b0;
                            if (r_occ != '0) r_occ <= r_occ - 1'b1;
                        end
                    end else if (r_found && i_func == FUNC_DEL) begin
                        for (int k = 0; k < CAPACITY; k++)
                            if (r_evld[k] && r_eage[k] > r_eage[r_e])
                                r_eage[k] <= r_eage[k] - 1'b1;
                        r_evld[r_e] <= 1'b0;
                        if (r_occ != '0) r_occ <= r_occ - 1'b1;
                        r_hit <= 1'b1; r_sd <= 1'b1;
                    end else if (i_func == FUNC_DEL && i_store) begin
                        r_sd <= 1'b1;
                    end else if (i_func == FUNC_PUT) begin
                        r_sw <= 1'b1;
                    end else begin
                        r_status <= 1'b1;
                    end
                end
                S_OUT: if (rsp.ready) r_st <= S_IDLE;
                default: r_st <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

/* rtl/lru_lfu_key_cache_directory_core.sv */
// Channel  Dir  Payload
// req      in   func, req_key, req_value, in_store
// rsp      out  status, hit, value_out, evict_valid, evict_key, store_write, store_delete
// cfg      in   index (0 policy, 1 capacity), data
// A request passes through S_IDLE, which picks up the queued beat, a pass over
// the entries for the key match and free slot (S_FIND), a pass for the victim
// (S_VICT), the update (S_UPD), and S_OUT, which presents the response.
// A stalled response holds the back end; the next request waits for the pop.
// The back end serves one request at a time; a two-beat queue takes requests
// while it works, until full. Reset (synchronous) clears valid, age and count.
`default_nettype none
module lru_lfu_key_cache_directory_core #(
    parameter int CAPACITY = 16,
    parameter int KEY_BITS = 32,
    parameter int VALUE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    lkc_req_if.sink   req,
    lkc_rsp_if.source rsp,
    lkc_cfg_if.sink   cfg
);
    import lkc_pkg::*;
    logic                  r_policy;
    logic [4:0]            r_cap;
    logic                  q_valid, pop, q_store;
    logic [1:0]            q_func;
    logic [KEY_BITS-1:0]   q_key;
    logic [VALUE_BITS-1:0] q_value;

    // configuration registers
    assign cfg.ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_policy <= 1'b0; r_cap <= 5'd16;
        end else if (cfg.valid) begin
            if (cfg.index == CFG_POLICY) r_policy <= cfg.data[0];
            else r_cap <= cfg.data;
        end
    end

    lkc_front #(.KB(KEY_BITS), .VB(VALUE_BITS)) u_front (
        .i_clk, .i_rst_n, .req, .i_pop(pop), .o_valid(q_valid), .o_func(q_func),
        .o_key(q_key), .o_value(q_value), .o_store(q_store));

    lkc_back #(.CAPACITY(CAPACITY), .KB(KEY_BITS), .VB(VALUE_BITS)) u_back (
        .i_clk, .i_rst_n, .i_valid(q_valid), .o_pop(pop), .i_func(q_func),
        .i_key(q_key), .i_value(q_value), .i_store(q_store), .i_policy(r_policy),
        .i_cap(r_cap), .rsp);
endmodule
`default_nettype wire

/* rtl/lkc_checker.sv */
`default_nettype none
`include "lru_lfu_key_cache_directory_core_macros.svh"
// Port-level checks on the response channel
module lkc_checker (
    input wire logic i_clk,
    input wire logic i_rst_n,
    input wire logic rsp_valid,
    input wire logic rsp_ready,
    input wire logic rsp_status,
    input wire logic rsp_hit,
    input wire logic rsp_sw,
    input wire logic rsp_sd,
    input wire logic rsp_evv
);
    // a failed request does nothing else
    `LKC_ASSERT_IMP(a_fail_quiet, i_clk, i_rst_n, rsp_valid && rsp_status,
        !rsp_hit && !rsp_sw && !rsp_sd && !rsp_evv)
    // never both write and delete
    `LKC_ASSERT_IMP(a_one_store_op, i_clk, i_rst_n, rsp_valid, !(rsp_sw && rsp_sd))
    // a taken response is not shown again next cycle
    `LKC_ASSERT_NEXT(a_no_repeat, i_clk, i_rst_n, rsp_valid && rsp_ready, !rsp_valid)
    // a stalled response stays
    `LKC_ASSERT_NEXT(a_hold, i_clk, i_rst_n, rsp_valid && !rsp_ready, rsp_valid)
endmodule

bind lru_lfu_key_cache_directory_core lkc_checker u_chk (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
    .rsp_status(rsp.status), .rsp_hit(rsp.hit), .rsp_sw(rsp.store_write),
    .rsp_sd(rsp.store_delete), .rsp_evv(rsp.evict_valid));
`default_nettype wire
